[rtl/core/assert_macros.svh]
// Shared assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define QWE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define QWE_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/core/qwe_pkg.sv]
package qwe_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_char;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } t_out;

    // Classified character handed from front to back
    typedef struct packed {
        logic [7:0] char_code;
        logic       first_char;
        logic       fold;
        logic       last_char;
        logic       esc;
    } t_job;

    typedef enum logic [3:0] {
        P_HEAD  = 4'b0001,
        P_FOLD  = 4'b0010,
        P_SYM   = 4'b0100,
        P_CLOSE = 4'b1000
    } t_phase;

    localparam logic [6:0] LimitReset = 7'd58;
    localparam int         QDepth     = 4;
    localparam int         QAw        = 2;

    localparam logic [3:0] HdrLast   = 4'd14;
    localparam logic [3:0] FoldLast  = 4'd4;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChEq    = 8'h3D;
    localparam logic [7:0] ChQm    = 8'h3F;
    localparam logic [7:0] ChUs    = 8'h5F;
    localparam logic [7:0] ChTilde = 8'h7E;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;

    // "=?iso-8859-1?Q?"
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = ChEq;
            4'd1:    b = ChQm;
            4'd2:    b = 8'h69;
            4'd3:    b = 8'h73;
            4'd4:    b = 8'h6F;
            4'd5:    b = 8'h2D;
            4'd6:    b = 8'h38;
            4'd7:    b = 8'h38;
            4'd8:    b = 8'h35;
            4'd9:    b = 8'h39;
            4'd10:   b = 8'h2D;
            4'd11:   b = 8'h31;
            4'd12:   b = ChQm;
            4'd13:   b = 8'h51;
            default: b = ChQm;
        endcase
        return b;
    endfunction

    // "?=" CR LF space
    function automatic logic [7:0] fold_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = ChQm;
            3'd1:    b = ChEq;
            3'd2:    b = ChCr;
            3'd3:    b = ChLf;
            default: b = ChSpace;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] b;
        if (nib < 4'd10) begin
            b = 8'h30 + {4'b0, nib};
        end else begin
            b = 8'h37 + {4'b0, nib};
        end
        return b;
    endfunction

endpackage

[rtl/core/qwe_front.sv]
`include "assert_macros.svh"

module qwe_front
    import qwe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  t_in        i_in_data,
    input  logic       i_q_ready,
    output logic       o_in_ready,
    output logic       o_push,
    output t_job       o_job
);

    logic [6:0] r_limit;
    logic [6:0] n_limit;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] base;
    logic [7:0] total;
    logic       esc;
    logic       over;
    logic [7:0] c;

    assign c = i_in_data.char_code;

    // space is not escaped: it maps to an underscore
    assign esc = (c < ChSpace) || (c == ChEq) || (c == ChQm) || (c == ChUs) || (c > ChTilde);

    assign base  = i_in_data.first_char ? 8'd0 : r_count;
    assign total = base + (esc ? 8'd3 : 8'd1);
    assign over  = total > {1'b0, r_limit};

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

    always_comb begin
        o_job.char_code  = c;
        o_job.first_char = i_in_data.first_char;
        o_job.fold       = over && !i_in_data.first_char;
        o_job.last_char  = i_in_data.last_char;
        o_job.esc        = esc;
    end

    always_comb begin
        n_limit = i_cfg_we ? i_cfg_wdata : r_limit;
        n_count = r_count;
        if (o_push) begin
            n_count = over ? 8'd0 : total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
            r_count <= 8'd0;
        end else begin
            r_limit <= n_limit;
            r_count <= n_count;
        end
    end

    // count is only kept when it stays within the 7-bit limit
    `QWE_NEVER(a_count_range, i_clk, i_rst_n, r_count[7], "line count above limit range")

endmodule

[rtl/core/qwe_fifo.sv]
`include "assert_macros.svh"

module qwe_fifo
    import qwe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_ready,
    output logic o_valid,
    output t_job o_data
);

    localparam logic [QAw:0] QFull = (QAw + 1)'(QDepth);

    t_job           r_mem [QDepth];
    logic [QAw-1:0] r_wp;
    logic [QAw-1:0] r_rp;
    logic [QAw:0]   r_cnt;
    logic [QAw-1:0] n_wp;
    logic [QAw-1:0] n_rp;
    logic [QAw:0]   n_cnt;

    assign o_ready = r_cnt != QFull;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + {{QAw{1'b0}}, i_push} - {{QAw{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    `QWE_ASSERT(a_no_overfill, i_clk, i_rst_n, r_cnt <= QFull, "queue count beyond depth")
    `QWE_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

[rtl/core/qwe_back.sv]
`include "assert_macros.svh"

module qwe_back
    import qwe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_idx;
    logic [3:0] n_idx;
    logic       r_started;
    logic       n_started;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out       r_out;

    t_phase     cur_phase;
    t_phase     nxt_phase;
    logic [3:0] cur_idx;
    logic [7:0] byte_val;
    logic       seg_end;
    logic       done;
    logic       adv;

    assign adv = i_job_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_started) begin
            cur_phase = r_phase;
            cur_idx   = r_idx;
        end else begin
            cur_idx = 4'd0;
            if (i_job.first_char) begin
                cur_phase = P_HEAD;
            end else if (i_job.fold) begin
                cur_phase = P_FOLD;
            end else begin
                cur_phase = P_SYM;
            end
        end
    end

    always_comb begin
        byte_val  = ChQm;
        seg_end   = 1'b0;
        done      = 1'b0;
        nxt_phase = P_SYM;
        unique case (cur_phase)
            P_HEAD: begin
                byte_val  = hdr_byte(cur_idx);
                seg_end   = cur_idx == HdrLast;
                nxt_phase = P_SYM;
            end
            P_FOLD: begin
                byte_val  = fold_byte(cur_idx[2:0]);
                seg_end   = cur_idx == FoldLast;
                nxt_phase = P_HEAD;
            end
            P_SYM: begin
                if (i_job.esc) begin
                    unique case (cur_idx[1:0])
                        2'd0:    byte_val = ChEq;
                        2'd1:    byte_val = hex_char(i_job.char_code[7:4]);
                        default: byte_val = hex_char(i_job.char_code[3:0]);
                    endcase
                    seg_end = cur_idx == 4'd2;
                end else begin
                    byte_val = (i_job.char_code == ChSpace) ? ChUs : i_job.char_code;
                    seg_end  = 1'b1;
                end
                nxt_phase = P_CLOSE;
                done      = seg_end && !i_job.last_char;
            end
            P_CLOSE: begin
                byte_val  = (cur_idx == 4'd0) ? ChQm : ChEq;
                seg_end   = cur_idx == 4'd1;
                done      = seg_end;
                nxt_phase = P_CLOSE;
            end
            default: begin
                byte_val = ChQm;
                seg_end  = 1'b1;
                done     = 1'b1;
            end
        endcase
    end

    assign o_pop = adv && done;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (adv) begin
            n_out_valid = 1'b1;
            if (done) begin
                n_started = 1'b0;
                n_idx     = 4'd0;
                n_phase   = P_SYM;
            end else if (seg_end) begin
                n_started = 1'b1;
                n_idx     = 4'd0;
                n_phase   = nxt_phase;
            end else begin
                n_started = 1'b1;
                n_idx     = cur_idx + 4'd1;
                n_phase   = cur_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_byte <= byte_val;
            r_out.run_end  <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_SYM;
            r_idx       <= 4'd0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a request leaves the queue only with its final byte
    `QWE_ASSERT(a_pop_marks_end, i_clk, i_rst_n, o_pop |=> (o_out_valid && o_out_data.run_end), "pop without run end")

endmodule

[rtl/core/rfc2047_q_word_encoder.sv]
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+---------------------------
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
// cfg     | input     | i_cfg_we                   | i_cfg_wdata (line_limit)
//
// One output byte per cycle while the output is not stalled; a request yields
// 1 to 25 bytes, issued by the single-byte emit sequencer in the back end.
// A 4-deep queue lets the front accept requests while the back is still emitting.
// Synchronous active-low reset: line_limit 58, count 0, queue and output empty.
// A stalled output holds its byte; the front stalls only when the queue is full.
module rfc2047_q_word_encoder
    import qwe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    qwe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_ready   (q_ready),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_job       (job_in)
    );

    qwe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    qwe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
